>>> hdl/packed_pointer_hash_table_unit_macros.svh
// assertion macros for the packed pointer hash table unit
`ifndef PACKED_POINTER_HASH_TABLE_UNIT_MACROS_SVH
`define PACKED_POINTER_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PPH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pph_pkg.sv
// shared types and constants of the packed pointer hash table unit
package pph_pkg;

  localparam int unsigned PTR_W_DEF       = 16;
  localparam int unsigned TABLE_DEPTH_DEF = 65536;

  localparam int unsigned FLD_PTR_W  = 16;
  localparam int unsigned FLD_HASH_W = 64;
  localparam int unsigned FLD_IDX_W  = 16;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned BIT_CNT_W  = 6;

  localparam logic [15:0] TABLE_ENTRIES_RST = 16'd65521;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_FIND   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_NOSLOT = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic mod_step;
    logic set_idx;
    logic rd;
    logic wr;
    logic adv;
    logic resp_full;
    logic resp_ins;
    logic resp_noslot;
    logic resp_find;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic is_find;
    logic full;
    logic slot_free;
    logic tries_out;
  } dp_sts_t;

endpackage

>>> hdl/pph_if.sv
// beat channels of the packed pointer hash table unit
interface pph_in_if import pph_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [FLD_PTR_W-1:0]  pointer_value;
  logic [FLD_HASH_W-1:0] home_hash;
  logic [FLD_HASH_W-1:0] step_hash;
  logic                  cursor_restart;

  modport source(output valid, cmd, pointer_value, home_hash, step_hash, cursor_restart,
                 input ready);
  modport sink(input valid, cmd, pointer_value, home_hash, step_hash, cursor_restart,
               output ready);
endinterface

interface pph_out_if import pph_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [FLD_IDX_W-1:0] slot_index;
  logic [FLD_PTR_W-1:0] found_pointer;
  logic                 slot_empty;

  modport source(output valid, status, slot_index, found_pointer, slot_empty, input ready);
  modport sink(input valid, status, slot_index, found_pointer, slot_empty, output ready);
endinterface

>>> hdl/pph_ctrl.sv
// controller state machine of the packed pointer hash table unit
module pph_ctrl import pph_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_IDX   = 6'b001000,
    ST_RD    = 6'b010000,
    ST_CHK   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   resp_r, resp_nxt;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    if (resp_r && out_ready) begin
      resp_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && !resp_r) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = ST_IDX;
      end
      ST_IDX: begin
        if (!sts.is_find && sts.full) begin
          cmd.resp_full = 1'b1;
          resp_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.set_idx = 1'b1;
          state_nxt   = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.is_find) begin
          cmd.resp_find = 1'b1;
          resp_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.wr       = 1'b1;
          cmd.resp_ins = 1'b1;
          resp_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (sts.tries_out) begin
          cmd.resp_noslot = 1'b1;
          resp_nxt        = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_RD;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      resp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE) && !resp_r;
  assign out_valid = resp_r;

endmodule

>>> hdl/pph_dp.sv
// datapath of the packed pointer hash table unit: slot memory, remainders, probe walk
module pph_dp import pph_pkg::*; #(
  parameter int unsigned PTR_W       = PTR_W_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_cmd,
  input  logic [FLD_PTR_W-1:0]  in_pointer_value,
  input  logic [FLD_HASH_W-1:0] in_home_hash,
  input  logic [FLD_HASH_W-1:0] in_step_hash,
  input  logic                  in_cursor_restart,
  output logic [1:0]            out_status,
  output logic [FLD_IDX_W-1:0]  out_slot_index,
  output logic [FLD_PTR_W-1:0]  out_found_pointer,
  output logic                  out_slot_empty,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [PTR_W-1:0]      mem [TABLE_DEPTH];
  logic [PTR_W-1:0]      rd_data_r;
  logic [AW:0]           clr_addr_r;
  logic [15:0]           te_r;
  logic [CNT_W-1:0]      n;
  logic                  cmd_r;
  logic                  first_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [FLD_HASH_W-1:0] a_r, b_r;
  logic [CNT_W-1:0]      arem_r, brem_r;
  logic [CNT_W-1:0]      arem_sh, brem_sh, arem_nxt, brem_nxt;
  logic [BIT_CNT_W-1:0]  bit_r;
  logic [CNT_W-1:0]      idx_r, idx_sum, idx_wrap, tries_r, count_r;
  logic [15:0]           cursor_r;
  logic [1:0]            status_r;
  logic [FLD_IDX_W-1:0]  slot_r;
  logic [FLD_PTR_W-1:0]  fp_r;
  logic                  empty_r;
  logic                  rd_empty;
  logic [AW-1:0]         addr;

  // slots in use: at least one, at most the memory depth
  always_comb begin
    if (te_r == 16'd0) n = CNT_W'(1);
    else if (32'(te_r) > 32'(TABLE_DEPTH)) n = CNT_W'(TABLE_DEPTH);
    else n = CNT_W'(te_r);
  end

  // one quotient bit per cycle for both remainders
  always_comb begin
    arem_sh  = {arem_r[CNT_W-2:0], a_r[FLD_HASH_W-1]};
    brem_sh  = {brem_r[CNT_W-2:0], b_r[FLD_HASH_W-1]};
    arem_nxt = (arem_sh >= n) ? arem_sh - n : arem_sh;
    brem_nxt = (brem_sh >= n) ? brem_sh - n : brem_sh;
  end

  // next probe slot, both terms below n
  always_comb begin
    if (cmd.set_idx) idx_sum = arem_r + brem_r;
    else idx_sum = idx_r + brem_r;
    idx_wrap = (idx_sum >= n) ? idx_sum - n : idx_sum;
  end

  assign addr     = AW'(idx_r);
  assign rd_empty = (rd_data_r == '1);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) mem[AW'(clr_addr_r)] <= '1;
    else if (cmd.wr) mem[addr] <= ptr_r;
    if (cmd.rd) rd_data_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      te_r       <= TABLE_ENTRIES_RST;
      count_r    <= '0;
      cursor_r   <= '0;
    end else begin
      if (cmd.clr_en) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_we) te_r <= cfg_wdata;
      if (cmd.wr) count_r <= count_r + 1'b1;
      if (cmd.set_idx && cmd_r == CMD_FIND) begin
        cursor_r <= 16'((first_r) ? arem_r : idx_wrap);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      first_r <= in_cursor_restart;
      ptr_r   <= PTR_W'(in_pointer_value);
      // a non-first find reduces the cursor instead of the hash
      if (in_cmd == CMD_FIND && !in_cursor_restart) a_r <= FLD_HASH_W'(cursor_r);
      else a_r <= in_home_hash;
      b_r    <= in_step_hash;
      arem_r <= '0;
      brem_r <= '0;
      bit_r  <= '0;
    end else if (cmd.mod_step) begin
      a_r    <= {a_r[FLD_HASH_W-2:0], 1'b0};
      b_r    <= {b_r[FLD_HASH_W-2:0], 1'b0};
      arem_r <= arem_nxt;
      brem_r <= brem_nxt;
      bit_r  <= bit_r + 1'b1;
    end
    if (cmd.set_idx) begin
      idx_r   <= (cmd_r == CMD_FIND && !first_r) ? idx_wrap : arem_r;
      tries_r <= '0;
    end else if (cmd.adv) begin
      idx_r   <= idx_wrap;
      tries_r <= tries_r + 1'b1;
    end
    if (cmd.resp_full || cmd.resp_noslot) begin
      status_r <= (cmd.resp_full) ? STS_FULL : STS_NOSLOT;
      slot_r   <= '0;
      fp_r     <= '0;
      empty_r  <= 1'b0;
    end else if (cmd.resp_ins) begin
      status_r <= STS_OK;
      slot_r   <= FLD_IDX_W'(idx_r);
      fp_r     <= '0;
      empty_r  <= 1'b0;
    end else if (cmd.resp_find) begin
      status_r <= STS_OK;
      slot_r   <= FLD_IDX_W'(idx_r);
      fp_r     <= FLD_PTR_W'(rd_data_r);
      empty_r  <= rd_empty;
    end
  end

  assign sts.clr_done  = (clr_addr_r == (AW+1)'(TABLE_DEPTH - 1));
  assign sts.mod_done  = (bit_r == '1);
  assign sts.is_find   = (cmd_r == CMD_FIND);
  assign sts.full      = (count_r >= n);
  assign sts.slot_free = rd_empty;
  assign sts.tries_out = ((tries_r + 1'b1) >= n);

  assign out_status        = status_r;
  assign out_slot_index    = slot_r;
  assign out_found_pointer = fp_r;
  assign out_slot_empty    = empty_r;

endmodule

>>> hdl/packed_pointer_hash_table_unit.sv
// top level of the packed pointer hash table unit
// usage:
//   in_ch carries one request beat: cmd (insert or find probe), pointer_value,
//   home_hash, step_hash and cursor_restart. out_ch returns one result beat per
//   request: status, slot_index, found_pointer and slot_empty. cfg_we / cfg_wdata
//   set table_entries; write it only while no request is in flight.
// sequence:
//   one request at a time: two bit-serial remainder units, side by side, reduce the
//   hash (the cursor, for a find without cursor_restart) and the step mod the table
//   size; then the start slot is chosen, or an insert into a full table is answered
//   at once; then each probe reads a slot of the slot memory, then checks it or
//   writes it. a find probes one slot only. in_ch.ready rises again in the cycle
//   after the result beat leaves.
// reset:
//   rst_n low clears the count, the probe cursor and the result channel and
//   sets table_entries to 65521. afterwards a clearing pass writes the empty
//   mark into every slot, with in_ch.ready held low.
// stall:
//   a result beat waits in its output register while out_ch.ready is low; the
//   next request is taken only once that beat has gone.
`include "packed_pointer_hash_table_unit_macros.svh"

module packed_pointer_hash_table_unit import pph_pkg::*; #(
  parameter int unsigned PTR_W       = PTR_W_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pph_in_if.sink       in_ch,
  pph_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  // command and status between controller and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // beat events watched by the checks below
  logic in_beat;
  logic fail_beat;

  pph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  pph_dp #(
    .PTR_W       (PTR_W),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_ch.cmd),
    .in_pointer_value  (in_ch.pointer_value),
    .in_home_hash      (in_ch.home_hash),
    .in_step_hash      (in_ch.step_hash),
    .in_cursor_restart (in_ch.cursor_restart),
    .out_status        (out_ch.status),
    .out_slot_index    (out_ch.slot_index),
    .out_found_pointer (out_ch.found_pointer),
    .out_slot_empty    (out_ch.slot_empty),
    .cmd               (dp_cmd),
    .sts               (dp_sts)
  );

  assign in_beat   = in_ch.valid && in_ch.ready;
  assign fail_beat = out_ch.valid && (out_ch.status != STS_OK);

  // a pending result beat blocks new requests
  `PPH_ASSERT_NOW(a_one_in_flight, clk, rst_n, out_ch.valid, !in_ch.ready, "request while busy")

  // an accepted request never answers in the next cycle
  `PPH_ASSERT_NEXT(a_no_early_beat, clk, rst_n, in_beat, !out_ch.valid, "result beat too early")

  // failed inserts report slot zero
  `PPH_ASSERT_NOW(a_fail_slot_zero, clk, rst_n, fail_beat, out_ch.slot_index == '0, "bad fail slot")

  // the controller never starts a write and a read together
  `PPH_ASSERT_NOW(a_mem_port, clk, rst_n, dp_cmd.wr, !dp_cmd.rd && !dp_cmd.clr_en, "port conflict")

endmodule

>>> tb/sv/pph_table_checker.sv
// result checker for the packed pointer hash table unit: predicts each beat and compares
`timescale 1ns / 100ps

module pph_table_checker import pph_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pph_in_if    in_ch,
  pph_out_if   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

  typedef struct {
    status_t     status;
    logic [15:0] slot_index;
    logic [15:0] found_pointer;
    logic        slot_empty;
  } table_answer_t;

  logic [15:0]   slot_copy [TABLE_DEPTH_DEF];
  logic [16:0]   entries_held;
  logic [15:0]   cursor;
  logic [15:0]   slots_set;
  table_answer_t answers_due [$];

  // work out the answer to one accepted request and update the table copy
  function automatic table_answer_t apply_request(logic is_find, logic [15:0] ptr,
                                                  logic [63:0] hash, logic [63:0] probe,
                                                  logic restart);
    table_answer_t a;
    logic [63:0] n;
    logic [63:0] stride;
    logic [63:0] at;
    n = (slots_set == 16'd0) ? 64'd1 : {48'd0, slots_set};
    stride = probe % n;
    a.status = STS_OK;
    a.slot_index = '0;
    a.found_pointer = '0;
    a.slot_empty = 1'b0;
    if (!is_find) begin
      if ({47'd0, entries_held} >= n) begin
        a.status = STS_FULL;
        return a;
      end
      at = hash % n;
      for (longint unsigned k = 0; k < n; k++) begin
        if (slot_copy[at[15:0]] == EMPTY_MARK) begin
          slot_copy[at[15:0]] = ptr;
          entries_held = entries_held + 17'd1;
          a.slot_index = at[15:0];
          return a;
        end
        at = (at + stride) % n;
      end
      a.status = STS_NOSLOT;
      return a;
    end
    at = restart ? hash % n : ({48'd0, cursor} + stride) % n;
    cursor = at[15:0];
    a.slot_index = at[15:0];
    a.found_pointer = slot_copy[at[15:0]];
    a.slot_empty = (slot_copy[at[15:0]] == EMPTY_MARK);
    return a;
  endfunction

  assign pending = answers_due.size();

  always @(posedge clk) begin
    table_answer_t got;
    table_answer_t want;
    if (!rst_n) begin
      foreach (slot_copy[i]) slot_copy[i] = EMPTY_MARK;
      entries_held = '0;
      cursor = '0;
      slots_set = TABLE_ENTRIES_RST;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) slots_set = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        answers_due.push_back(apply_request(in_ch.cmd == CMD_FIND, in_ch.pointer_value,
                                            in_ch.home_hash, in_ch.step_hash,
                                            in_ch.cursor_restart));
      if (out_ch.valid && out_ch.ready) begin
        got.status = status_t'(out_ch.status);
        got.slot_index = out_ch.slot_index;
        got.found_pointer = out_ch.found_pointer;
        got.slot_empty = out_ch.slot_empty;
        if (answers_due.size() == 0) begin
          $error("result beat with no request waiting");
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d actual %0d", want.slot_index, got.slot_index);
            fail_count++;
          end
          if (got.found_pointer !== want.found_pointer) begin
            $error("found_pointer: expected %0d actual %0d", want.found_pointer,
                   got.found_pointer);
            fail_count++;
          end
          if (got.slot_empty !== want.slot_empty) begin
            $error("slot_empty: expected %0d actual %0d", want.slot_empty, got.slot_empty);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/packed_pointer_hash_table_unit_test.sv
// stimulus and verdict for the packed pointer hash table unit
`timescale 1ns / 100ps

module packed_pointer_hash_table_unit_test;
  import pph_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;

  // the sender reads these; the receiver reads calm and beats_sent as well
  logic        calm = 1'b0;       // no idling at all in the last phase
  logic        sender_idles = 1'b1;
  int          beats_sent = 0;
  int unsigned cur_n = 65521;

  pph_in_if  in_ch ();
  pph_out_if out_ch ();

  packed_pointer_hash_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  pph_table_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // offer one request beat, starting right after a rising edge, and hold it until taken
  task automatic offer_request(cmd_t c, logic [15:0] ptr, logic [63:0] hash,
                               logic [63:0] probe, logic restart);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.pointer_value <= ptr;
    in_ch.home_hash <= hash;
    in_ch.step_hash <= probe;
    in_ch.cursor_restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    // random gaps on the sender side, only in some phases
    if (!calm && sender_idles && ($urandom % 5 == 0)) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // change the table size once every outstanding result has come back
  task automatic set_table_size(logic [15:0] size);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_n = (size == 16'd0) ? 1 : size;
    @(posedge clk);
  endtask

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  // one random request, with small hashes and short strides where the table is small
  task automatic offer_random_request();
    cmd_t        c;
    logic [63:0] hash;
    logic [63:0] probe;
    c = ($urandom % 2) ? CMD_FIND : CMD_INSERT;
    hash = wide_random();
    probe = wide_random();
    if (cur_n <= 300 && ($urandom % 4 == 0)) hash = 64'($urandom_range(0, 40));
    if (cur_n <= 300 && ($urandom % 4 == 0)) probe = 64'($urandom_range(0, 3));
    offer_request(c, 16'($urandom_range(0, 65535)), hash, probe, ($urandom % 4 == 0));
  endtask

  // receiver: random hold-offs, one long stall to back the block up
  initial begin
    int hold_left;
    int burst_left;
    bit long_done;
    hold_left = 0;
    burst_left = 0;
    long_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_done && beats_sent >= 300) begin
        long_done = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && ($urandom % 6 == 0)) begin
        burst_left = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // main stimulus
  initial begin
    logic [15:0] sizes [8];
    sizes = '{16'd7, 16'd0, 16'd65535, 16'd13, 16'd257, 16'd2, 16'd65521, 16'd65535};
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_INSERT;
    in_ch.pointer_value = '0;
    in_ch.home_hash = '0;
    in_ch.step_hash = '0;
    in_ch.cursor_restart = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset table size
    offer_request(CMD_INSERT, 16'h0000, 64'd0, 64'd1, 1'b1);
    offer_request(CMD_INSERT, 16'hFFFF, 64'd1, 64'd1, 1'b0);   // reserved pointer
    offer_request(CMD_INSERT, 16'h1234, 64'd1, 64'd1, 1'b0);
    offer_request(CMD_INSERT, 16'h00FF, 64'd0, 64'd1, 1'b0);   // walks two slots
    offer_request(CMD_INSERT, 16'hFFFE, '1, '1, 1'b0);
    offer_request(CMD_FIND, 16'hABCD, 64'd0, 64'd5, 1'b1);
    offer_request(CMD_FIND, 16'h5555, 64'd9, 64'd1, 1'b0);
    offer_request(CMD_FIND, 16'h0000, 64'd0, '1, 1'b0);
    offer_request(CMD_FIND, 16'hFFFF, '1, 64'd0, 1'b1);
    offer_request(CMD_FIND, 16'h0000, 64'd3, 64'd0, 1'b1);

    // shrunk table: count already near the size
    set_table_size(16'd7);
    offer_request(CMD_INSERT, 16'h0042, 64'd0, 64'd0, 1'b0);   // stride zero, no slot
    offer_request(CMD_INSERT, 16'h0043, 64'd3, 64'd0, 1'b0);
    offer_request(CMD_INSERT, 16'h0044, 64'd4, 64'd7, 1'b0);
    offer_request(CMD_INSERT, 16'h0045, 64'd5, 64'd1, 1'b0);   // table full
    offer_request(CMD_FIND, 16'h0000, 64'd100, 64'd3, 1'b1);
    offer_request(CMD_FIND, 16'h0000, 64'd0, 64'd6, 1'b0);
    offer_request(CMD_FIND, 16'h0000, 64'd0, '1, 1'b0);

    foreach (sizes[p]) begin
      if (p > 0) set_table_size(sizes[p]);
      sender_idles = (p % 2 == 0);
      calm = (p == 7);
      repeat (160) offer_random_request();
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("packed_pointer_hash_table_unit test passed");
    end else begin
      $display("packed_pointer_hash_table_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #100ms;
    $display("packed_pointer_hash_table_unit test failed");
    $finish;
  end

endmodule

>>> packed_pointer_hash_table_unit.f
+incdir+hdl
hdl/pph_pkg.sv
hdl/pph_if.sv
hdl/pph_ctrl.sv
hdl/pph_dp.sv
hdl/packed_pointer_hash_table_unit.sv
tb/sv/pph_table_checker.sv
tb/sv/packed_pointer_hash_table_unit_test.sv
